// File: rtl/nclg_pkg.sv
// ----------------------------------------------------------------------------
// nclg_pkg
// Types, register addresses and constants shared by the noise channel.
// ----------------------------------------------------------------------------
package nclg_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE    = 3'd0,
    CMD_READ     = 3'd1,
    CMD_FREQ     = 3'd2,
    CMD_LENGTH   = 3'd3,
    CMD_ENVELOPE = 3'd4
  } nclg_cmd_e;

  localparam logic [7:0] ADDR_NR41 = 8'h20;
  localparam logic [7:0] ADDR_NR42 = 8'h21;
  localparam logic [7:0] ADDR_NR43 = 8'h22;
  localparam logic [7:0] ADDR_NR44 = 8'h23;

  localparam logic [14:0] LFSR_FULL    = 15'h7FFF;
  localparam logic [6:0]  LENGTH_FULL  = 7'd64;
  localparam logic [7:0]  DAC_MASK     = 8'hF8;
  localparam logic [3:0]  ENV_RELOAD   = 4'd8;
  localparam logic [3:0]  VOLUME_MAX   = 4'd15;

  typedef struct packed {
    logic [5:0]  length_reg;
    logic [7:0]  envelope_reg;
    logic [7:0]  poly_reg;
    logic [1:0]  control_reg;
    logic [6:0]  length_count;
    logic [22:0] period_timer;
    logic [3:0]  envelope_timer;
    logic        envelope_active;
    logic [3:0]  volume;
    logic [14:0] shift_reg;
    logic        channel_on;
    logic        dac_on;
    logic [3:0]  out_level;
  } nclg_state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] sample;
    logic       running;
  } nclg_result_t;

  function automatic logic [6:0] divisor(input logic [2:0] code);
    logic [6:0] d;
    case (code)
      3'd0:    d = 7'd8;
      3'd1:    d = 7'd16;
      3'd2:    d = 7'd32;
      3'd3:    d = 7'd48;
      3'd4:    d = 7'd64;
      3'd5:    d = 7'd80;
      3'd6:    d = 7'd96;
      default: d = 7'd112;
    endcase
    return d;
  endfunction

  function automatic logic [22:0] period_value(input logic [7:0] poly);
    logic [22:0] base;
    base = {16'd0, divisor(poly[2:0])};
    return base << poly[7:4];
  endfunction

endpackage

// File: rtl/nclg_core.sv
// ----------------------------------------------------------------------------
// nclg_core
// Channel state and the single-step update for one command beat.
// ----------------------------------------------------------------------------
module nclg_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [2:0]            cmd_i,
  input  logic [7:0]            addr_i,
  input  logic [7:0]            wdata_i,
  output nclg_pkg::nclg_result_t result_o
);

  nclg_pkg::nclg_state_t state_q, state_d;
  logic [7:0] rd;
  logic       fb;
  logic [2:0] per;

  always_comb begin
    state_d = state_q;
    rd      = 8'd0;
    fb      = state_q.shift_reg[0] ^ state_q.shift_reg[1];
    per     = state_q.envelope_reg[2:0];
    unique case (cmd_i)
      nclg_pkg::CMD_WRITE: begin
        case (addr_i)
          nclg_pkg::ADDR_NR41: begin
            state_d.length_reg   = wdata_i[5:0];
            state_d.length_count = nclg_pkg::LENGTH_FULL - {1'b0, wdata_i[5:0]};
          end
          nclg_pkg::ADDR_NR42: begin
            state_d.dac_on       = (wdata_i & nclg_pkg::DAC_MASK) != 8'd0;
            state_d.envelope_reg = wdata_i;
          end
          nclg_pkg::ADDR_NR43: begin
            state_d.poly_reg = wdata_i;
          end
          nclg_pkg::ADDR_NR44: begin
            state_d.control_reg = wdata_i[7:6];
            if (wdata_i[6] || wdata_i[7]) begin
              state_d.channel_on = 1'b1;
              if (state_q.length_count == 7'd0) begin
                state_d.length_count = nclg_pkg::LENGTH_FULL;
              end
            end
            if (wdata_i[7]) begin
              state_d.period_timer    = nclg_pkg::period_value(state_q.poly_reg);
              state_d.envelope_timer  = {1'b0, state_q.envelope_reg[2:0]};
              state_d.envelope_active = 1'b1;
              state_d.volume          = state_q.envelope_reg[7:4];
              state_d.shift_reg       = nclg_pkg::LFSR_FULL;
            end
          end
          default: ;
        endcase
      end
      nclg_pkg::CMD_READ: begin
        case (addr_i)
          nclg_pkg::ADDR_NR41: rd = {2'b00, state_q.length_reg};
          nclg_pkg::ADDR_NR42: rd = state_q.envelope_reg;
          nclg_pkg::ADDR_NR43: rd = state_q.poly_reg;
          nclg_pkg::ADDR_NR44: rd = {state_q.control_reg, 6'd0};
          default:             rd = 8'd0;
        endcase
      end
      nclg_pkg::CMD_FREQ: begin
        if (state_q.period_timer > 23'd1) begin
          state_d.period_timer = state_q.period_timer - 23'd1;
        end else begin
          state_d.period_timer = nclg_pkg::period_value(state_q.poly_reg);
          state_d.shift_reg    = {fb, state_q.shift_reg[14:1]};
          if (state_q.poly_reg[3]) begin
            state_d.shift_reg[6] = fb;
          end
          state_d.out_level = (state_q.channel_on && state_q.dac_on &&
                               !state_d.shift_reg[0]) ? state_q.volume : 4'd0;
        end
      end
      nclg_pkg::CMD_LENGTH: begin
        if (state_q.length_count != 7'd0 && state_q.control_reg[0]) begin
          state_d.length_count = state_q.length_count - 7'd1;
          if (state_q.length_count == 7'd1) begin
            state_d.channel_on = 1'b0;
          end
        end
      end
      nclg_pkg::CMD_ENVELOPE: begin
        if (state_q.envelope_timer > 4'd1) begin
          state_d.envelope_timer = state_q.envelope_timer - 4'd1;
        end else begin
          state_d.envelope_timer = (per == 3'd0) ? nclg_pkg::ENV_RELOAD : {1'b0, per};
          if (state_q.envelope_active && per != 3'd0) begin
            if (state_q.envelope_reg[3] && state_q.volume < nclg_pkg::VOLUME_MAX) begin
              state_d.volume = state_q.volume + 4'd1;
            end else if (!state_q.envelope_reg[3] && state_q.volume != 4'd0) begin
              state_d.volume = state_q.volume - 4'd1;
            end
          end
          if (state_d.volume == 4'd0 || state_d.volume == nclg_pkg::VOLUME_MAX) begin
            state_d.envelope_active = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (en_i) begin
      state_q <= state_d;
    end
  end

  assign result_o.read_data = rd;
  assign result_o.sample    = state_d.out_level;
  assign result_o.running   = state_d.channel_on & state_d.dac_on;

endmodule

// File: rtl/noise_channel_lfsr_generator.sv
// ----------------------------------------------------------------------------
// noise_channel_lfsr_generator
// Sound-chip noise channel: register port, length counter, envelope and LFSR.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tuser: command; tdata: address, write_data
// m_axis    out        tdata: read_data, sample, running
//
// One beat is taken every cycle while m_axis is not stalled; each beat gives one
// result beat, passing through the input register and then the result register
// around a single state-update step. Reset clears all channel state to zero.
// A stall on m_axis holds the result register, and s_axis keeps taking beats
// until the input register is also full.
// ----------------------------------------------------------------------------
module noise_channel_lfsr_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] address, [15:8] write_data
  input  logic [2:0]  s_axis_tuser,  // [2:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [7:0] read_data, [11:8] sample, [12] running
);

  logic        in_valid_q;
  logic [2:0]  cmd_q;
  logic [7:0]  addr_q;
  logic [7:0]  wdata_q;
  logic        out_valid_q;
  nclg_pkg::nclg_result_t res_q;
  nclg_pkg::nclg_result_t res;
  logic        exec;

  assign exec          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q   <= s_axis_tuser;
      addr_q  <= s_axis_tdata[7:0];
      wdata_q <= s_axis_tdata[15:8];
    end
    if (exec) begin
      res_q <= res;
    end
  end

  nclg_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (exec),
    .cmd_i    (cmd_q),
    .addr_i   (addr_q),
    .wdata_i  (wdata_q),
    .result_o (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.running, res_q.sample, res_q.read_data};

endmodule

// File: rtl/nclg_checker.sv
// ----------------------------------------------------------------------------
// nclg_checker
// Port-level checks of the noise channel, bound to the top level.
// ----------------------------------------------------------------------------
module nclg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Result beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("Result beat changed while stalled.");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
    else $error("Accepted beat did not reach the output.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("Input stalled without a pending result.");

endmodule

bind noise_channel_lfsr_generator nclg_checker u_nclg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
